>>> sv/kmst_pkg.sv
package kmst_pkg;

    localparam int MAX_NODES   = 64;
    localparam int EDGE_SLOTS  = 256;
    localparam int WEIGHT_BITS = 16;
    localparam int NODE_W      = $clog2(MAX_NODES);
    localparam int EADDR_W     = $clog2(EDGE_SLOTS);
    localparam int ECNT_W      = EADDR_W + 1;
    localparam int NCFG_W      = NODE_W + 1;

    localparam logic [NCFG_W-1:0] NODE_COUNT_RST = NCFG_W'(MAX_NODES);

    typedef struct packed {
        logic [NODE_W-1:0]             end_a;
        logic [NODE_W-1:0]             end_b;
        logic signed [WEIGHT_BITS-1:0] edge_weight;
        logic                          has_edge;
        logic                          final_item;
    } in_t;

    typedef struct packed {
        logic [NODE_W-1:0]             tree_end_a;
        logic [NODE_W-1:0]             tree_end_b;
        logic signed [WEIGHT_BITS-1:0] tree_weight;
        logic                          edge_valid;
        logic                          run_end;
        logic [NODE_W-1:0]             tree_size;
        logic                          dropped_flag;
    } out_t;

    typedef struct packed {
        logic signed [WEIGHT_BITS-1:0] w;
        logic [NODE_W-1:0]             b;
        logic [NODE_W-1:0]             a;
    } edge_t;

endpackage

>>> sv/kruskal_minimum_spanning_tree_unit.sv
// Loading: one edge per cycle while s_ready is high (ready only between runs).
// Run: insertion sort over the edge memory, then union-find over the parent
// memory; the edge and parent memories have one read port each. Results
// follow one at a time as the output register frees. Reset (aresetn low,
// synchronous) empties the edge store, marks all vertices as roots and sets
// node_count 64.
module kruskal_minimum_spanning_tree_unit (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  kmst_pkg::in_t                s_data,
    output logic                         m_valid,
    input  logic                         m_ready,
    output kmst_pkg::out_t               m_data,
    input  logic                         cfg_we,
    input  logic [kmst_pkg::NCFG_W-1:0]  cfg_wdata
);
    import kmst_pkg::*;

    localparam logic [3:0] ST_LOAD = 4'd0;
    localparam logic [3:0] ST_RD   = 4'd1;
    localparam logic [3:0] ST_CUR  = 4'd2;
    localparam logic [3:0] ST_CMP  = 4'd3;
    localparam logic [3:0] ST_PUT  = 4'd4;
    localparam logic [3:0] ST_ERD  = 4'd5;
    localparam logic [3:0] ST_EDGE = 4'd6;
    localparam logic [3:0] ST_FA   = 4'd7;
    localparam logic [3:0] ST_FAW  = 4'd8;
    localparam logic [3:0] ST_FB   = 4'd9;
    localparam logic [3:0] ST_FBW  = 4'd10;
    localparam logic [3:0] ST_JOIN = 4'd11;
    localparam logic [3:0] ST_OUT  = 4'd12;
    localparam logic [3:0] ST_FIN  = 4'd13;

    localparam logic [NODE_W-1:0] ACC_MAX = {NODE_W{1'b1}};

    edge_t             edge_mem [EDGE_SLOTS];
    logic [NODE_W-1:0] par_mem  [MAX_NODES];

    logic              e_we;
    logic [EADDR_W-1:0] e_waddr, e_raddr;
    edge_t             e_wdata, e_rdata;
    logic              p_we;
    logic [NODE_W-1:0] p_waddr, p_wdata, p_raddr, p_rdata;

    logic [3:0]         state_reg, state_next;
    logic [ECNT_W-1:0]  cnt_reg, cnt_next;
    logic [ECNT_W-1:0]  idx_reg, idx_next;
    logic [EADDR_W-1:0] j_reg, j_next;
    edge_t              cur_reg, cur_next;
    edge_t              held_reg, held_next;
    logic               have_held_reg, have_held_next;
    logic               ovf_reg, ovf_next;
    logic               drop_reg, drop_next;
    logic [NODE_W-1:0]  acc_reg, acc_next;
    logic [NODE_W-1:0]  v_reg, v_next;
    logic [NODE_W-1:0]  ra_reg, ra_next;
    logic [MAX_NODES-1:0] linked_reg, linked_next;
    logic [NCFG_W-1:0]  ncount_reg, ncount_next;
    logic               m_valid_reg, m_valid_next;
    out_t               m_data_reg, m_data_next;

    logic out_free;
    logic [ECNT_W-1:0] idx_inc;

    assign out_free = !m_valid_reg || m_ready;
    assign idx_inc  = idx_reg + ECNT_W'(1);
    assign s_ready  = (state_reg == ST_LOAD);
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    always_ff @(posedge aclk) begin
        if (e_we) begin
            edge_mem[e_waddr] <= e_wdata;
        end
        e_rdata <= edge_mem[e_raddr];
    end

    always_ff @(posedge aclk) begin
        if (p_we) begin
            par_mem[p_waddr] <= p_wdata;
        end
        p_rdata <= par_mem[p_raddr];
    end

    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        idx_next       = idx_reg;
        j_next         = j_reg;
        cur_next       = cur_reg;
        held_next      = held_reg;
        have_held_next = have_held_reg;
        ovf_next       = ovf_reg;
        drop_next      = drop_reg;
        acc_next       = acc_reg;
        v_next         = v_reg;
        ra_next        = ra_reg;
        linked_next    = linked_reg;
        ncount_next    = cfg_we ? cfg_wdata : ncount_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_data_next    = m_data_reg;
        e_we           = 1'b0;
        e_waddr        = cnt_reg[EADDR_W-1:0];
        e_wdata        = '{w: s_data.edge_weight, b: s_data.end_b, a: s_data.end_a};
        e_raddr        = idx_reg[EADDR_W-1:0];
        p_we           = 1'b0;
        p_waddr        = ra_reg;
        p_wdata        = v_reg;
        p_raddr        = v_reg;

        unique case (state_reg)
            ST_LOAD: begin
                if (s_valid) begin
                    if (s_data.has_edge) begin
                        if (!cnt_reg[EADDR_W]) begin
                            e_we     = 1'b1;
                            cnt_next = cnt_reg + ECNT_W'(1);
                        end else begin
                            ovf_next = 1'b1;
                        end
                    end
                    if (s_data.final_item) begin
                        drop_next      = ovf_next;
                        linked_next    = '0;
                        have_held_next = 1'b0;
                        acc_next       = '0;
                        idx_next       = ECNT_W'(1);
                        state_next     = ST_RD;
                    end
                end
            end
            ST_RD: begin
                // sort done once idx reaches the count; start the scan
                if (idx_reg >= cnt_reg) begin
                    idx_next   = '0;
                    state_next = ST_ERD;
                end else begin
                    state_next = ST_CUR;
                end
            end
            ST_CUR: begin
                cur_next   = e_rdata;
                j_next     = idx_reg[EADDR_W-1:0];
                e_raddr    = idx_reg[EADDR_W-1:0] - EADDR_W'(1);
                state_next = ST_CMP;
            end
            ST_CMP: begin
                e_we    = 1'b1;
                e_waddr = j_reg;
                if (e_rdata.w > cur_reg.w) begin
                    e_wdata = e_rdata;
                    j_next  = j_reg - EADDR_W'(1);
                    e_raddr = j_reg - EADDR_W'(2);
                    if (j_reg == EADDR_W'(1)) begin
                        state_next = ST_PUT;
                    end
                end else begin
                    e_wdata    = cur_reg;
                    idx_next   = idx_inc;
                    state_next = ST_RD;
                end
            end
            ST_PUT: begin
                e_we       = 1'b1;
                e_waddr    = '0;
                e_wdata    = cur_reg;
                idx_next   = idx_inc;
                state_next = ST_RD;
            end
            ST_ERD: begin
                if (idx_reg == cnt_reg) begin
                    state_next = ST_FIN;
                end else begin
                    state_next = ST_EDGE;
                end
            end
            ST_EDGE: begin
                cur_next = e_rdata;
                idx_next = idx_inc;
                if ({1'b0, e_rdata.a} < ncount_reg && {1'b0, e_rdata.b} < ncount_reg) begin
                    v_next     = e_rdata.a;
                    state_next = ST_FA;
                end else begin
                    state_next = ST_ERD;
                end
            end
            ST_FA: begin
                if (!linked_reg[v_reg]) begin
                    ra_next    = v_reg;
                    v_next     = cur_reg.b;
                    state_next = ST_FB;
                end else begin
                    state_next = ST_FAW;
                end
            end
            ST_FAW: begin
                v_next     = p_rdata;
                state_next = ST_FA;
            end
            ST_FB: begin
                if (!linked_reg[v_reg]) begin
                    state_next = ST_JOIN;
                end else begin
                    state_next = ST_FBW;
                end
            end
            ST_FBW: begin
                v_next     = p_rdata;
                state_next = ST_FB;
            end
            ST_JOIN: begin
                // v holds the root of end_b; link root of end_a under it
                if (ra_reg != v_reg && acc_reg != ACC_MAX) begin
                    p_we                = 1'b1;
                    linked_next[ra_reg] = 1'b1;
                    if (have_held_reg) begin
                        state_next = ST_OUT;
                    end else begin
                        held_next      = cur_reg;
                        have_held_next = 1'b1;
                        acc_next       = acc_reg + NODE_W'(1);
                        state_next     = ST_ERD;
                    end
                end else begin
                    state_next = ST_ERD;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = '{tree_end_a: held_reg.a, tree_end_b: held_reg.b,
                                     tree_weight: held_reg.w, edge_valid: 1'b1,
                                     run_end: 1'b0, tree_size: '0,
                                     dropped_flag: drop_reg};
                    held_next    = cur_reg;
                    acc_next     = acc_reg + NODE_W'(1);
                    state_next   = ST_ERD;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    if (have_held_reg) begin
                        m_data_next = '{tree_end_a: held_reg.a, tree_end_b: held_reg.b,
                                        tree_weight: held_reg.w, edge_valid: 1'b1,
                                        run_end: 1'b1, tree_size: acc_reg,
                                        dropped_flag: drop_reg};
                    end else begin
                        m_data_next = '{tree_end_a: '0, tree_end_b: '0,
                                        tree_weight: '0, edge_valid: 1'b0,
                                        run_end: 1'b1, tree_size: '0,
                                        dropped_flag: drop_reg};
                    end
                    cnt_next   = '0;
                    ovf_next   = 1'b0;
                    state_next = ST_LOAD;
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_LOAD;
            cnt_reg       <= '0;
            ovf_reg       <= 1'b0;
            have_held_reg <= 1'b0;
            acc_reg       <= '0;
            linked_reg    <= '0;
            ncount_reg    <= NODE_COUNT_RST;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            ovf_reg       <= ovf_next;
            have_held_reg <= have_held_next;
            acc_reg       <= acc_next;
            linked_reg    <= linked_next;
            ncount_reg    <= ncount_next;
            m_valid_reg   <= m_valid_next;
        end
        idx_reg    <= idx_next;
        j_reg      <= j_next;
        cur_reg    <= cur_next;
        held_reg   <= held_next;
        drop_reg   <= drop_next;
        v_reg      <= v_next;
        ra_reg     <= ra_next;
        m_data_reg <= m_data_next;
    end

`ifndef NO_ASSERTIONS
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= ECNT_W'(EDGE_SLOTS))
        else $error("edge count beyond capacity");

    a_mid_has_edge: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.run_end |-> m_data.edge_valid)
        else $error("result before run end without an edge");

    a_empty_size: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.edge_valid |-> m_data.tree_size == '0 && m_data.run_end)
        else $error("empty tree result malformed");

    a_no_load_in_run: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != ST_LOAD |=> !(s_valid && s_ready) || $past(state_reg) == ST_FIN)
        else $error("input taken during a run");
`endif

endmodule
